// ===== rtl/plel_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies; used by the sequencer and the top level.
package plel_pkg;

    localparam int DATA_W     = 32;
    localparam int FIELD_W    = 5;
    localparam int MAX_RESULTS = 16;

    localparam logic [2:0] KIND_INS_FRONT = 3'd0;
    localparam logic [2:0] KIND_INS_BACK  = 3'd1;
    localparam logic [2:0] KIND_INS_AT    = 3'd2;
    localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
    localparam logic [2:0] KIND_DEL_AT    = 3'd5;
    localparam logic [2:0] KIND_LIST      = 3'd6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_STATUS,
        S_LIST_RD,
        S_LIST_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]                kind;
        logic signed [DATA_W-1:0]  value;
        logic [FIELD_W-1:0]        position;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  element;
        logic [FIELD_W-1:0]        element_index;
        logic [FIELD_W-1:0]        count;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

endpackage

// ===== rtl/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Positional list engine: ordered list of signed 32-bit values in one RAM.
// Insert and delete move the affected entries one per cycle; list results leave one
// per cycle unless the output stalls. A new request is taken only once the previous
// request has handed its last result to the output register.
// Synchronous active-low reset empties the list; RAM is not cleared.
module positional_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  plel_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output plel_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    plel_pkg::t_push              push;
    logic                         slot_free;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [plel_pkg::DATA_W-1:0]  wdata;
    logic                         re;
    logic [AW-1:0]                raddr;
    logic [plel_pkg::DATA_W-1:0]  rdata;

    logic                         r_out_valid;
    plel_pkg::t_out_item          r_out_item;

    plel_ram #(
        .DEPTH  (CAPACITY),
        .AW     (AW),
        .DATA_W (plel_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    plel_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_push      (push),
        .i_slot_free (slot_free),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // output register: load when empty or being drained
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && push.valid) begin
            r_out_item <= push.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/plel_ram.sv =====
`timescale 1ns / 1ps
// Element store: one write port, one read port, registered read data.
// Depends on nothing; read data holds until the next read.
module plel_ram #(
    parameter int DEPTH  = 16,
    parameter int AW     = 4,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/plel_seq.sv =====
`timescale 1ns / 1ps
// Operation sequencer: decodes requests, shifts entries through the element
// store one per cycle, keeps the length and issues result pushes. Uses plel_pkg.
module plel_seq #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int LW       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  plel_pkg::t_in_item            i_in_item,
    output plel_pkg::t_push               o_push,
    input  logic                          i_slot_free,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [plel_pkg::DATA_W-1:0]   o_wdata,
    output logic                          o_re,
    output logic [AW-1:0]                 o_raddr,
    input  logic [plel_pkg::DATA_W-1:0]   i_rdata
);

    localparam int EW = LW + 6;

    plel_pkg::t_state           r_state, n_state;
    logic [LW-1:0]              r_len, n_len;
    logic [AW-1:0]              r_src, n_src;
    logic [LW-1:0]              r_left, n_left;
    logic                       r_wv, n_wv;
    logic [AW-1:0]              r_wa, n_wa;
    logic                       r_ins, n_ins;
    logic [plel_pkg::DATA_W-1:0] r_value, n_value;
    logic [AW-1:0]              r_put, n_put;
    plel_pkg::t_status          r_status, n_status;

    logic [EW-1:0] len_e;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] op_pos_e;
    logic [EW-1:0] idx_e;
    logic          is_ins;
    logic          is_del;
    logic          list_last;

    assign len_e = EW'(r_len);
    assign pos_e = EW'(i_in_item.position);
    assign idx_e = EW'(r_src) + EW'(1);
    assign list_last = (idx_e == len_e) || (idx_e == EW'(plel_pkg::MAX_RESULTS));

    always_comb begin
        op_pos_e = pos_e;
        is_ins   = 1'b0;
        is_del   = 1'b0;
        unique case (i_in_item.kind)
            plel_pkg::KIND_INS_FRONT: begin
                op_pos_e = EW'(1);
                is_ins   = 1'b1;
            end
            plel_pkg::KIND_INS_BACK: begin
                op_pos_e = len_e + EW'(1);
                is_ins   = 1'b1;
            end
            plel_pkg::KIND_INS_AT: begin
                is_ins = 1'b1;
            end
            plel_pkg::KIND_DEL_FRONT: begin
                op_pos_e = EW'(1);
                is_del   = 1'b1;
            end
            plel_pkg::KIND_DEL_BACK: begin
                op_pos_e = len_e;
                is_del   = 1'b1;
            end
            plel_pkg::KIND_DEL_AT: begin
                is_del = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plel_pkg::S_IDLE;
            r_len   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_wv    <= n_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_left   <= n_left;
        r_wa     <= n_wa;
        r_ins    <= n_ins;
        r_value  <= n_value;
        r_put    <= n_put;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_src    = r_src;
        n_left   = r_left;
        n_wv     = r_wv;
        n_wa     = r_wa;
        n_ins    = r_ins;
        n_value  = r_value;
        n_put    = r_put;
        n_status = r_status;

        o_in_ready = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_wa;
        o_wdata    = i_rdata;
        o_re       = 1'b0;
        o_raddr    = r_src;

        o_push.valid              = 1'b0;
        o_push.item.status        = r_status;
        o_push.item.element       = '0;
        o_push.item.element_index = '0;
        o_push.item.count         = len_e[plel_pkg::FIELD_W-1:0];
        o_push.item.last          = 1'b1;

        unique case (r_state)
            plel_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_value  = i_in_item.value;
                    n_put    = AW'(op_pos_e - EW'(1));
                    n_wv     = 1'b0;
                    n_status = plel_pkg::ST_OK;
                    n_state  = plel_pkg::S_STATUS;
                    if (i_in_item.kind == plel_pkg::KIND_LIST) begin
                        if (r_len == '0) begin
                            n_status = plel_pkg::ST_EMPTY;
                        end else begin
                            n_src   = '0;
                            n_state = plel_pkg::S_LIST_RD;
                        end
                    end else if (is_ins) begin
                        if (len_e >= EW'(CAPACITY)) begin
                            n_status = plel_pkg::ST_FULL;
                        end else if (op_pos_e == '0 || op_pos_e > len_e + EW'(1)) begin
                            n_status = plel_pkg::ST_BADPOS;
                        end else begin
                            // move entries pos-1 .. len-1 up by one, top first
                            n_src   = AW'(len_e - EW'(1));
                            n_left  = LW'(len_e - op_pos_e + EW'(1));
                            n_ins   = 1'b1;
                            n_state = plel_pkg::S_SHIFT;
                        end
                    end else if (is_del) begin
                        if (r_len == '0) begin
                            n_status = plel_pkg::ST_EMPTY;
                        end else if (op_pos_e == '0 || op_pos_e > len_e) begin
                            n_status = plel_pkg::ST_BADPOS;
                        end else begin
                            // move entries pos .. len-1 down by one, bottom first
                            n_src   = AW'(op_pos_e);
                            n_left  = LW'(len_e - op_pos_e);
                            n_ins   = 1'b0;
                            n_state = plel_pkg::S_SHIFT;
                        end
                    end
                end
            end

            plel_pkg::S_SHIFT: begin
                // write back the entry read last cycle while reading the next
                o_we = r_wv;
                if (r_left != '0) begin
                    o_re   = 1'b1;
                    n_wv   = 1'b1;
                    n_left = r_left - LW'(1);
                    if (r_ins) begin
                        n_wa  = r_src + AW'(1);
                        n_src = r_src - AW'(1);
                    end else begin
                        n_wa  = r_src - AW'(1);
                        n_src = r_src + AW'(1);
                    end
                end else begin
                    n_wv = 1'b0;
                    if (r_ins) begin
                        n_state = plel_pkg::S_PUT;
                    end else begin
                        n_len   = r_len - LW'(1);
                        n_state = plel_pkg::S_STATUS;
                    end
                end
            end

            plel_pkg::S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_put;
                o_wdata = r_value;
                n_len   = r_len + LW'(1);
                n_state = plel_pkg::S_STATUS;
            end

            plel_pkg::S_STATUS: begin
                o_push.valid = 1'b1;
                if (i_slot_free) begin
                    n_state = plel_pkg::S_IDLE;
                end
            end

            plel_pkg::S_LIST_RD: begin
                o_re    = 1'b1;
                n_state = plel_pkg::S_LIST_EMIT;
            end

            plel_pkg::S_LIST_EMIT: begin
                o_push.valid              = 1'b1;
                o_push.item.status        = plel_pkg::ST_OK;
                o_push.item.element       = i_rdata;
                o_push.item.element_index = idx_e[plel_pkg::FIELD_W-1:0];
                o_push.item.last          = list_last;
                if (i_slot_free) begin
                    if (list_last) begin
                        n_state = plel_pkg::S_IDLE;
                    end else begin
                        // fetch the next element as this one leaves
                        o_re    = 1'b1;
                        o_raddr = r_src + AW'(1);
                        n_src   = r_src + AW'(1);
                    end
                end
            end

            default: begin
                n_state = plel_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/positional_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine_unit: random and directed list requests,
// with results checked against an in-bench list model. Depends on plel_pkg and the RTL.
module positional_list_engine_unit_test;

    localparam int         CAPACITY       = 16;
    localparam logic [2:0] KIND_UNUSED    = 3'd7;
    localparam int         IDLE_PCT       = 24;
    localparam int         HOLDOFF_CYCLES = 300;
    localparam int         QUIET_LIMIT    = 5000;
    localparam int         SETTLE_CYCLES  = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    plel_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready = 1'b0;
    plel_pkg::t_out_item out_item;

    // list model state
    logic signed [plel_pkg::DATA_W-1:0] list_vals [CAPACITY];
    int                                 list_len = 0;
    plel_pkg::t_out_item                pending_results [$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    bit steady_flow   = 1'b0;
    int holdoff_count = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    positional_list_engine_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #10 clk = ~clk;

    function automatic plel_pkg::t_out_item status_result(plel_pkg::t_status st);
        plel_pkg::t_out_item r;
        r.status        = st;
        r.element       = '0;
        r.element_index = '0;
        r.count         = list_len[plel_pkg::FIELD_W-1:0];
        r.last          = 1'b1;
        return r;
    endfunction

    function automatic plel_pkg::t_status insert_entry(int pos,
                                                       logic signed [plel_pkg::DATA_W-1:0] v);
        if (list_len >= CAPACITY) return plel_pkg::ST_FULL;
        if (pos < 1 || pos > list_len + 1) return plel_pkg::ST_BADPOS;
        for (int i = list_len; i >= pos; i--)
            list_vals[i] = list_vals[i-1];
        list_vals[pos-1] = v;
        list_len++;
        return plel_pkg::ST_OK;
    endfunction

    function automatic plel_pkg::t_status remove_entry(int pos);
        if (list_len == 0) return plel_pkg::ST_EMPTY;
        if (pos < 1 || pos > list_len) return plel_pkg::ST_BADPOS;
        for (int i = pos; i < list_len; i++)
            list_vals[i-1] = list_vals[i];
        list_len--;
        return plel_pkg::ST_OK;
    endfunction

    // Apply one accepted request to the list model and queue the results it owes.
    task automatic model_request(input plel_pkg::t_in_item req);
        plel_pkg::t_out_item r;
        int                  n;
        case (req.kind)
            plel_pkg::KIND_INS_FRONT:
                pending_results.push_back(status_result(insert_entry(1, req.value)));
            plel_pkg::KIND_INS_BACK:
                pending_results.push_back(
                    status_result(insert_entry(list_len + 1, req.value)));
            plel_pkg::KIND_INS_AT:
                pending_results.push_back(
                    status_result(insert_entry(int'(req.position), req.value)));
            plel_pkg::KIND_DEL_FRONT:
                pending_results.push_back(status_result(remove_entry(1)));
            plel_pkg::KIND_DEL_BACK:
                pending_results.push_back(status_result(remove_entry(list_len)));
            plel_pkg::KIND_DEL_AT:
                pending_results.push_back(
                    status_result(remove_entry(int'(req.position))));
            plel_pkg::KIND_LIST: begin
                if (list_len == 0) begin
                    pending_results.push_back(status_result(plel_pkg::ST_EMPTY));
                end else begin
                    n = (list_len < plel_pkg::MAX_RESULTS) ? list_len : plel_pkg::MAX_RESULTS;
                    for (int i = 0; i < n; i++) begin
                        r.status        = plel_pkg::ST_OK;
                        r.element       = list_vals[i];
                        r.element_index = plel_pkg::FIELD_W'(i + 1);
                        r.count         = list_len[plel_pkg::FIELD_W-1:0];
                        r.last          = (i + 1 == n);
                        pending_results.push_back(r);
                    end
                end
            end
            default: pending_results.push_back(status_result(plel_pkg::ST_OK));
        endcase
    endtask

    task automatic send_request(input logic [2:0] kind,
                                input logic signed [plel_pkg::DATA_W-1:0] value,
                                input logic [plel_pkg::FIELD_W-1:0] position);
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item.kind     = kind;
        in_item.value    = value;
        in_item.position = position;
        in_valid         = 1'b1;
        do @(posedge clk); while (!in_ready);
        model_request(in_item);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [plel_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position, sometimes anything the field can hold.
    function automatic logic [plel_pkg::FIELD_W-1:0] pick_position(int lo, int hi);
        if ($urandom_range(99) < 80) return plel_pkg::FIELD_W'($urandom_range(hi, lo));
        return plel_pkg::FIELD_W'($urandom_range(31));
    endfunction

    task automatic note_mismatch(string field, longint exp_v, longint got_v);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    endtask

    always @(posedge clk) begin : check_results
        plel_pkg::t_out_item exp_item;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
            end else begin
                exp_item = pending_results.pop_front();
                if (out_item.status !== exp_item.status)
                    note_mismatch("status", exp_item.status, out_item.status);
                if (out_item.element !== exp_item.element)
                    note_mismatch("element", exp_item.element, out_item.element);
                if (out_item.element_index !== exp_item.element_index)
                    note_mismatch("element_index", exp_item.element_index,
                                  out_item.element_index);
                if (out_item.count !== exp_item.count)
                    note_mismatch("count", exp_item.count, out_item.count);
                if (out_item.last !== exp_item.last)
                    note_mismatch("last", exp_item.last, out_item.last);
            end
        end
    end

    // Result side: random stalls, a long hold-off on request, steady during the no-idle stretch.
    always @(negedge clk) begin
        if (holdoff_seen != holdoff_count) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_seen = holdoff_count;
        end
        if (holdoff_left > 0) begin
            out_ready = 1'b0;
            holdoff_left--;
        end else if (steady_flow) begin
            out_ready = 1'b1;
        end else begin
            out_ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_empty_list();
        send_request(plel_pkg::KIND_DEL_FRONT, pick_value(), 5'd1);
        send_request(plel_pkg::KIND_DEL_BACK, pick_value(), 5'd0);
        send_request(plel_pkg::KIND_DEL_AT, pick_value(), 5'd1);
        send_request(plel_pkg::KIND_DEL_AT, pick_value(), 5'd0);
        send_request(plel_pkg::KIND_LIST, pick_value(), 5'd31);
        send_request(plel_pkg::KIND_INS_AT, 32'sd5, 5'd0);
        send_request(plel_pkg::KIND_INS_AT, 32'sd6, 5'd2);
        send_request(plel_pkg::KIND_INS_AT, 32'sd7, 5'd31);
        send_request(KIND_UNUSED, 32'sh7FFF_FFFF, 5'd31);
    endtask

    task automatic test_edge_values();
        send_request(plel_pkg::KIND_INS_FRONT, 32'sh8000_0000, 5'd0);
        send_request(plel_pkg::KIND_INS_BACK, 32'sh7FFF_FFFF, 5'd31);
        send_request(plel_pkg::KIND_INS_AT, '0, 5'd2);
        send_request(plel_pkg::KIND_INS_AT, -32'sd1, 5'd4);
        send_request(plel_pkg::KIND_INS_AT, 32'sd9, 5'd6);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd5);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd0);
        send_request(plel_pkg::KIND_LIST, '0, 5'd0);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd2);
        send_request(plel_pkg::KIND_DEL_BACK, '0, 5'd0);
        send_request(plel_pkg::KIND_DEL_FRONT, '0, 5'd0);
        send_request(plel_pkg::KIND_LIST, -32'sd1, 5'd31);
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
            send_request(plel_pkg::KIND_INS_BACK, pick_value(),
                         plel_pkg::FIELD_W'($urandom_range(31)));
        // full check wins over the position check
        send_request(plel_pkg::KIND_INS_FRONT, 32'sd1, 5'd1);
        send_request(plel_pkg::KIND_INS_AT, 32'sd2, 5'd31);
        send_request(plel_pkg::KIND_INS_AT, 32'sd3, 5'd17);
        send_request(plel_pkg::KIND_INS_BACK, 32'sd4, 5'd0);
        send_request(plel_pkg::KIND_LIST, '0, 5'd0);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd17);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd16);
        send_request(plel_pkg::KIND_INS_AT, 32'sh8000_0000, 5'd16);
        send_request(plel_pkg::KIND_DEL_AT, '0, 5'd8);
        send_request(plel_pkg::KIND_INS_AT, 32'sh7FFF_FFFF, 5'd1);
        send_request(plel_pkg::KIND_LIST, '0, 5'd0);
        while (list_len > 0)
            send_request($urandom_range(1) ? plel_pkg::KIND_DEL_FRONT : plel_pkg::KIND_DEL_BACK,
                         '0, '0);
    endtask

    // Stall the result side while requests keep coming, then let everything drain.
    task automatic test_backpressure();
        holdoff_count++;
        for (int n = 0; n < 12; n++)
            send_request((n % 3 == 2) ? plel_pkg::KIND_LIST : plel_pkg::KIND_INS_FRONT,
                         pick_value(), plel_pkg::FIELD_W'($urandom_range(31)));
        drain_results();
        send_request(plel_pkg::KIND_LIST, '0, '0);
    endtask

    task automatic test_random_walk(int num);
        int                          target;
        int                          r;
        logic [2:0]                  kind;
        logic [plel_pkg::FIELD_W-1:0] pos;
        target = CAPACITY;
        for (int n = 0; n < num; n++) begin
            // swing the list between nearly empty and nearly full
            if (n % 30 == 0)
                target = (target > CAPACITY / 2) ? $urandom_range(3, 0)
                                                 : $urandom_range(CAPACITY, 13);
            steady_flow = (n >= 60 && n < 100);
            r = $urandom_range(99);
            if (r < 3) begin
                kind = KIND_UNUSED;
            end else if (r < 13) begin
                kind = plel_pkg::KIND_LIST;
            end else if ((list_len < target) ? (r < 83) : (r >= 83)) begin
                case ($urandom_range(2))
                    0:       kind = plel_pkg::KIND_INS_FRONT;
                    1:       kind = plel_pkg::KIND_INS_BACK;
                    default: kind = plel_pkg::KIND_INS_AT;
                endcase
            end else begin
                case ($urandom_range(2))
                    0:       kind = plel_pkg::KIND_DEL_FRONT;
                    1:       kind = plel_pkg::KIND_DEL_BACK;
                    default: kind = plel_pkg::KIND_DEL_AT;
                endcase
            end
            if (kind == plel_pkg::KIND_INS_AT)
                pos = pick_position(1, list_len + 1);
            else if (kind == plel_pkg::KIND_DEL_AT)
                pos = pick_position(1, (list_len > 0) ? list_len : 1);
            else
                pos = plel_pkg::FIELD_W'($urandom_range(31));
            send_request(kind, pick_value(), pos);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_backpressure();
        test_random_walk(135);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/plel_pkg.sv
rtl/plel_ram.sv
rtl/plel_seq.sv
rtl/positional_list_engine_unit.sv
sim/positional_list_engine_unit_test.sv
